// ===== rtl/btl_pkg.sv =====
`default_nettype none
package btl_pkg;

   // tree dimensions
   localparam int MAX_NODES = 1024;
   localparam int MAX_KIDS  = 16;

   // derived widths
   localparam int ADDR_W  = $clog2(MAX_NODES);
   localparam int NODE_W  = $clog2(MAX_NODES + 1);
   localparam int SUM_W   = NODE_W + 1;
   localparam int COUNT_W = $clog2(MAX_KIDS + 1);

   // fixed field widths of the ports
   localparam int IN_COUNT_W = 5;
   localparam int INDEX_W    = 10;
   localparam int STAGE_W    = 10;
   localparam int SIB_W      = 4;
   localparam int REAL_W     = 4;
   localparam int STATUS_W   = 2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_CREATED = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic take;        // latch an accepted request
      logic emit_child;  // produce one child result
      logic emit_flag;   // produce the single error result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic flag;        // request is flagged (overflow or not created)
      logic leaf;        // no children
      logic last_child;  // current child is the final one
      logic out_free;    // result register can take a new transaction
   } sts_type;

endpackage
`default_nettype wire

// ===== rtl/bfs_tree_labeler.sv =====
`default_nettype none
// Breadth-first tree labeler. Each req_ transaction gives the child count of
// one node, nodes in breadth-first order, req_first marking the root of a new
// tree. Each child yields one rsp_ transaction with its index (from a running
// next-free counter), parent, stage, sibling place and realization; rsp_last
// marks the final one. A leaf yields nothing. A node not yet created, or a
// node whose children would overflow the 1024-entry node store, yields one
// flagged transaction (status 2 or 1) and nothing is assigned. Counts above
// 16 saturate to 16. Timing: one request at a time; the per-child emit loop
// produces one child a cycle while the result register is free (it stalls on
// rsp_ready), through the single write port of the stage and realization
// stores. A registered result stage lets the last result wait for rsp_ready
// while the next request is taken.
module bfs_tree_labeler import btl_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_first,
   input  wire logic [IN_COUNT_W-1:0] req_child_count,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [INDEX_W-1:0]         rsp_child_index,
   output logic [INDEX_W-1:0]         rsp_parent_index,
   output logic [STAGE_W-1:0]         rsp_child_stage,
   output logic [SIB_W-1:0]           rsp_sibling_pos,
   output logic [REAL_W-1:0]          rsp_realization,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_last
);

   cmd_type cmd;
   sts_type sts;

   // sequencing: take a request, then emit its results
   btl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // counters, node stores and the result register
   btl_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_first        (req_first),
      .req_child_count  (req_child_count),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_child_index  (rsp_child_index),
      .rsp_parent_index (rsp_parent_index),
      .rsp_child_stage  (rsp_child_stage),
      .rsp_sibling_pos  (rsp_sibling_pos),
      .rsp_realization  (rsp_realization),
      .rsp_status       (rsp_status),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire

// ===== rtl/btl_ctrl.sv =====
`default_nettype none
module btl_ctrl import btl_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_WORK = 1'b1;

   logic state_ff;
   logic state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      req_ready      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = S_WORK;
            end
         end
         S_WORK: begin
            if (sts.flag) begin
               if (sts.out_free) begin
                  cmd.emit_flag = 1'b1;
                  state_in      = S_IDLE;
               end
            end else if (sts.leaf) begin
               state_in = S_IDLE;
            end else if (sts.out_free) begin
               cmd.emit_child = 1'b1;
               if (sts.last_child) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/btl_dp.sv =====
`default_nettype none
module btl_dp import btl_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output sts_type                    sts,
   input  wire logic                  req_first,
   input  wire logic [IN_COUNT_W-1:0] req_child_count,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [INDEX_W-1:0]         rsp_child_index,
   output logic [INDEX_W-1:0]         rsp_parent_index,
   output logic [STAGE_W-1:0]         rsp_child_stage,
   output logic [SIB_W-1:0]           rsp_sibling_pos,
   output logic [REAL_W-1:0]          rsp_realization,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic                       rsp_last
);

   // counters
   logic [NODE_W-1:0]  node_counter_ff, node_counter_in;
   logic [NODE_W-1:0]  next_free_ff, next_free_in;

   // latched request
   logic [NODE_W-1:0]  node_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] idx_ff;
   logic               not_created_ff, overflow_ff, leaf_ff, node_zero_ff;

   // node stores, read on take only
   logic [STAGE_W-1:0] stage_mem [MAX_NODES];
   logic [REAL_W-1:0]  real_mem  [MAX_NODES];
   logic [STAGE_W-1:0] stage_rd_ff;
   logic [REAL_W-1:0]  real_rd_ff;

   // result register
   logic                rsp_valid_ff;
   logic [INDEX_W-1:0]  child_index_ff, parent_index_ff;
   logic [STAGE_W-1:0]  child_stage_ff;
   logic [SIB_W-1:0]    sibling_pos_ff;
   logic [REAL_W-1:0]   realization_ff;
   logic [STATUS_W-1:0] status_ff;
   logic                last_ff;

   // request decode
   logic [NODE_W-1:0]  node_sel;
   logic [NODE_W-1:0]  nf_base;
   logic [COUNT_W-1:0] count_sat;
   logic [SUM_W-1:0]   nf_sum;

   // child values
   logic [NODE_W-1:0]  child_node;
   logic [ADDR_W-1:0]  child_addr;
   logic [STAGE_W-1:0] child_stage;
   logic [REAL_W-1:0]  child_real;
   logic               out_free;

   always_comb begin
      node_sel  = req_first ? '0 : node_counter_ff;
      nf_base   = req_first ? NODE_W'(1) : next_free_ff;
      count_sat = (req_child_count > IN_COUNT_W'(MAX_KIDS)) ? COUNT_W'(MAX_KIDS)
                                                            : COUNT_W'(req_child_count);
      nf_sum    = SUM_W'(nf_base) + SUM_W'(count_sat);
   end

   always_comb begin
      child_node  = next_free_ff + NODE_W'(idx_ff);
      child_addr  = ADDR_W'(child_node);
      child_stage = node_zero_ff ? STAGE_W'(1) : stage_rd_ff + STAGE_W'(1);
      if (count_ff > COUNT_W'(1)) begin
         child_real = REAL_W'(idx_ff);
      end else if (node_zero_ff) begin
         child_real = '0;
      end else begin
         child_real = real_rd_ff;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      sts.flag       = not_created_ff || overflow_ff;
      sts.leaf       = leaf_ff;
      sts.last_child = (idx_ff + COUNT_W'(1)) == count_ff;
      sts.out_free   = out_free;
   end

   // counter next values
   always_comb begin
      node_counter_in = node_counter_ff;
      next_free_in    = next_free_ff;
      if (cmd.take) begin
         node_counter_in = (node_sel < NODE_W'(MAX_NODES)) ? node_sel + NODE_W'(1)
                                                           : NODE_W'(MAX_NODES);
         next_free_in    = nf_base;
      end else if (cmd.emit_child && sts.last_child) begin
         next_free_in    = next_free_ff + NODE_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_counter_ff <= '0;
         next_free_ff    <= NODE_W'(1);
         rsp_valid_ff    <= 1'b0;
      end else begin
         node_counter_ff <= node_counter_in;
         next_free_ff    <= next_free_in;
         if (cmd.emit_child || cmd.emit_flag) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request and iteration registers
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         node_ff        <= node_sel;
         count_ff       <= count_sat;
         idx_ff         <= '0;
         not_created_ff <= (node_sel >= nf_base) || (node_sel >= NODE_W'(MAX_NODES));
         overflow_ff    <= nf_sum > SUM_W'(MAX_NODES);
         leaf_ff        <= count_sat == '0;
         node_zero_ff   <= node_sel == '0;
      end else if (cmd.emit_child) begin
         idx_ff <= idx_ff + COUNT_W'(1);
      end
   end

   // node stores
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         stage_rd_ff <= stage_mem[ADDR_W'(node_sel)];
         real_rd_ff  <= real_mem[ADDR_W'(node_sel)];
      end
      if (cmd.emit_child) begin
         stage_mem[child_addr] <= child_stage;
         real_mem[child_addr]  <= child_real;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (cmd.emit_child) begin
         child_index_ff  <= INDEX_W'(child_node);
         parent_index_ff <= INDEX_W'(node_ff);
         child_stage_ff  <= child_stage;
         sibling_pos_ff  <= SIB_W'(idx_ff);
         realization_ff  <= child_real;
         status_ff       <= ST_OK;
         last_ff         <= sts.last_child;
      end else if (cmd.emit_flag) begin
         child_index_ff  <= '0;
         parent_index_ff <= INDEX_W'(node_ff);
         child_stage_ff  <= '0;
         sibling_pos_ff  <= '0;
         realization_ff  <= '0;
         status_ff       <= not_created_ff ? ST_NOT_CREATED : ST_OVERFLOW;
         last_ff         <= 1'b1;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_child_index  = child_index_ff;
   assign rsp_parent_index = parent_index_ff;
   assign rsp_child_stage  = child_stage_ff;
   assign rsp_sibling_pos  = sibling_pos_ff;
   assign rsp_realization  = realization_ff;
   assign rsp_status       = status_ff;
   assign rsp_last         = last_ff;

endmodule
`default_nettype wire
